// File: hw/rtl/blt_pkg.sv
// Shared constants for the bone local transform pipeline.
package blt_pkg;

    localparam int QUAT_BITS     = 64;  // packed quaternion word on the input bus
    localparam int LEN2_BITS     = 64;  // squared length accumulates with this ceiling
    localparam int ROT_WIDTH_DEF = 16;  // quaternion component, Q2.14
    localparam int POS_WIDTH_DEF = 24;  // translation component, Q16.8
    localparam int QUAT_COMPS    = 4;
    localparam int VEC_COMPS     = 3;

endpackage

// File: hw/rtl/blt_inverse.sv
// Pipelined parent quaternion inverse: squared length, overflow test and long division.
module blt_inverse
    import blt_pkg::*;
#(
    parameter int ROT_WIDTH  = ROT_WIDTH_DEF,
    parameter int SIDE_WIDTH = 1
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [QUAT_BITS-1:0]            parent_quat,
    input  logic [SIDE_WIDTH-1:0]           side_in,
    output logic                            out_valid,
    output logic [QUAT_COMPS*ROT_WIDTH-1:0] inv,
    output logic                            degenerate,
    output logic [SIDE_WIDTH-1:0]           side_out
);

    localparam int RW    = ROT_WIDTH;
    localparam int EXT_W = (QUAT_COMPS * RW > QUAT_BITS) ? QUAT_COMPS * RW : QUAT_BITS;
    localparam int LEN_W = 2 * RW + 1;
    localparam int REM_W = LEN_W + 1;
    localparam int CMP_W = 3 * RW + 2;
    localparam int NSTEP = RW + 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        {LEN_W{1'b1}} >> ((LEN_W > LEN2_BITS) ? (LEN_W - LEN2_BITS) : 0);
    localparam logic [RW:0]   HALF_MAG = (RW + 1)'(1) << (RW - 1);
    localparam logic [RW-1:0] POS_MAX  = {1'b0, {(RW - 1){1'b1}}};
    localparam logic [RW-1:0] NEG_MIN  = {1'b1, {(RW - 1){1'b0}}};

    // Stage A: unpacked parent components.
    logic [EXT_W-1:0]      ext_word;
    logic signed [RW-1:0]  p_a_next [QUAT_COMPS];
    logic signed [RW-1:0]  p_a_reg  [QUAT_COMPS];
    logic [SIDE_WIDTH-1:0] side_a_reg;
    logic                  vld_a_reg;

    always_comb
    begin
        ext_word = EXT_W'(parent_quat);
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            p_a_next[k] = signed'(ext_word[(QUAT_COMPS - 1 - k) * RW +: RW]);
        end
    end

    // Stage B: squares, magnitudes and result signs.
    logic signed [RW-1:0]   negp_b      [QUAT_COMPS];
    logic signed [2*RW-1:0] sq_b_signed [QUAT_COMPS];
    logic [RW-1:0]          mag_b_next  [QUAT_COMPS];
    logic [2*RW-1:0]        sq_b_next   [QUAT_COMPS];
    logic [RW-1:0]          mag_b_reg   [QUAT_COMPS];
    logic [2*RW-1:0]        sq_b_reg    [QUAT_COMPS];
    logic [QUAT_COMPS-1:0]  neg_b_next;
    logic [QUAT_COMPS-1:0]  neg_b_reg;
    logic [SIDE_WIDTH-1:0]  side_b_reg;
    logic                   vld_b_reg;

    always_comb
    begin
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            negp_b[k]      = -p_a_reg[k];
            sq_b_signed[k] = p_a_reg[k] * p_a_reg[k];
            sq_b_next[k]   = sq_b_signed[k];
            mag_b_next[k]  = p_a_reg[k][RW-1] ? negp_b[k] : p_a_reg[k];
            // The vector part of the inverse is negated, as in the conjugate.
            neg_b_next[k]  = p_a_reg[k][RW-1] ^ (k != QUAT_COMPS - 1);
        end
    end

    // Stage C: squared length with its 64-bit ceiling.
    logic [LEN_W-1:0]      len_sum;
    logic [LEN_W-1:0]      den_c_next;
    logic [LEN_W-1:0]      den_c_reg;
    logic                  deg_c_reg;
    logic [RW-1:0]         mag_c_reg [QUAT_COMPS];
    logic [QUAT_COMPS-1:0] neg_c_reg;
    logic [SIDE_WIDTH-1:0] side_c_reg;
    logic                  vld_c_reg;

    always_comb
    begin
        len_sum = LEN_W'(sq_b_reg[0]) + LEN_W'(sq_b_reg[1])
                + LEN_W'(sq_b_reg[2]) + LEN_W'(sq_b_reg[3]);
        den_c_next = (len_sum > LEN_CAP) ? LEN_CAP : len_sum;
    end

    // Stage D: quotient overflow test and initial remainder.  The quotient of
    // mag * 2^(2F+1) / len2 only matters below 2^RW + 1, so the division
    // needs RW + 1 quotient bits and the rest is caught by one compare.
    logic [CMP_W-1:0]      num_d   [QUAT_COMPS];
    logic [CMP_W-1:0]      lim_d;
    logic [QUAT_COMPS-1:0] ovr_d_next;
    logic [REM_W-1:0]      rem_d_next [QUAT_COMPS];

    always_comb
    begin
        lim_d = (CMP_W'(den_c_reg) << RW) + CMP_W'(den_c_reg);
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            num_d[k]      = CMP_W'(mag_c_reg[k]) << (2 * RW - 3);
            ovr_d_next[k] = (num_d[k] >= lim_d);
            rem_d_next[k] = REM_W'(mag_c_reg[k]) << (RW - 4);
        end
    end

    // Division stages: index 0 is the output of stage D.
    logic [REM_W-1:0]      rem_reg  [NSTEP+1][QUAT_COMPS];
    logic [NSTEP-1:0]      quo_reg  [NSTEP+1][QUAT_COMPS];
    logic [LEN_W-1:0]      den_reg  [NSTEP+1];
    logic [QUAT_COMPS-1:0] ovr_reg  [NSTEP+1];
    logic [QUAT_COMPS-1:0] neg_reg  [NSTEP+1];
    logic                  deg_reg  [NSTEP+1];
    logic [SIDE_WIDTH-1:0] side_reg [NSTEP+1];
    logic                  vld_reg  [NSTEP+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg  <= 1'b0;
            vld_b_reg  <= 1'b0;
            vld_c_reg  <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            vld_a_reg  <= in_valid;
            vld_b_reg  <= vld_a_reg;
            vld_c_reg  <= vld_b_reg;
            vld_reg[0] <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_a_reg     <= p_a_next;
            side_a_reg  <= side_in;
            mag_b_reg   <= mag_b_next;
            sq_b_reg    <= sq_b_next;
            neg_b_reg   <= neg_b_next;
            side_b_reg  <= side_a_reg;
            den_c_reg   <= den_c_next;
            deg_c_reg   <= (len_sum == '0);
            mag_c_reg   <= mag_b_reg;
            neg_c_reg   <= neg_b_reg;
            side_c_reg  <= side_b_reg;
            rem_reg[0]  <= rem_d_next;
            for (int k = 0; k < QUAT_COMPS; k++)
            begin
                quo_reg[0][k] <= '0;
            end
            den_reg[0]  <= den_c_reg;
            ovr_reg[0]  <= ovr_d_next;
            neg_reg[0]  <= neg_c_reg;
            deg_reg[0]  <= deg_c_reg;
            side_reg[0] <= side_c_reg;
        end
    end

    // One restoring quotient bit per stage for all four components.
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        logic [REM_W-1:0] shl_rem  [QUAT_COMPS];
        logic [REM_W-1:0] rem_next [QUAT_COMPS];
        logic [NSTEP-1:0] quo_next [QUAT_COMPS];
        logic             fits     [QUAT_COMPS];

        always_comb
        begin
            for (int k = 0; k < QUAT_COMPS; k++)
            begin
                shl_rem[k]  = {rem_reg[j][k][REM_W-2:0], 1'b0};
                fits[k]     = (shl_rem[k] >= REM_W'(den_reg[j]));
                rem_next[k] = fits[k] ? (shl_rem[k] - REM_W'(den_reg[j])) : shl_rem[k];
                quo_next[k] = {quo_reg[j][k][NSTEP-2:0], fits[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j+1]  <= rem_next;
                quo_reg[j+1]  <= quo_next;
                den_reg[j+1]  <= den_reg[j];
                ovr_reg[j+1]  <= ovr_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                deg_reg[j+1]  <= deg_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // Stage E: round half away from zero, apply sign, saturate.
    logic [RW:0]                     qr_e     [QUAT_COMPS];
    logic [RW-1:0]                   qneg_e   [QUAT_COMPS];
    logic [QUAT_COMPS*RW-1:0]        inv_next;
    logic [QUAT_COMPS*RW-1:0]        inv_reg;
    logic                            deg_e_reg;
    logic [SIDE_WIDTH-1:0]           side_e_reg;
    logic                            vld_e_reg;

    always_comb
    begin
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            qr_e[k]   = (quo_reg[NSTEP][k] + (RW + 1)'(1)) >> 1;
            qneg_e[k] = RW'(-qr_e[k]);
            if (deg_reg[NSTEP])
                inv_next[k*RW +: RW] = '0;
            else if (ovr_reg[NSTEP][k])
                inv_next[k*RW +: RW] = neg_reg[NSTEP][k] ? NEG_MIN : POS_MAX;
            else if (neg_reg[NSTEP][k])
                inv_next[k*RW +: RW] = qneg_e[k];
            else if (qr_e[k] == HALF_MAG)
                inv_next[k*RW +: RW] = POS_MAX;
            else
                inv_next[k*RW +: RW] = qr_e[k][RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_e_reg <= 1'b0;
        else if (ce)
            vld_e_reg <= vld_reg[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            inv_reg    <= inv_next;
            deg_e_reg  <= deg_reg[NSTEP];
            side_e_reg <= side_reg[NSTEP];
        end
    end

    assign out_valid  = vld_e_reg;
    assign inv        = inv_reg;
    assign degenerate = deg_e_reg;
    assign side_out   = side_e_reg;

endmodule

// File: hw/rtl/blt_rotate.sv
// Pipelined quaternion product and translation rotation by the parent inverse.
module blt_rotate
    import blt_pkg::*;
#(
    parameter int ROT_WIDTH = ROT_WIDTH_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic [QUAT_COMPS*ROT_WIDTH-1:0]     inv,
    input  logic                                degenerate,
    input  logic [QUAT_COMPS*ROT_WIDTH-1:0]     child_rot,
    input  logic [VEC_COMPS*(POS_WIDTH+1)-1:0]  delta,
    output logic                                out_valid,
    output logic [QUAT_COMPS*ROT_WIDTH-1:0]     local_rot,
    output logic [VEC_COMPS*POS_WIDTH-1:0]      local_pos,
    output logic                                out_degenerate
);

    localparam int RW    = ROT_WIDTH;
    localparam int PW    = POS_WIDTH;
    localparam int DW    = PW + 1;
    localparam int F     = RW - 2;
    localparam int MAXP  = (2 * RW > RW + DW) ? 2 * RW : RW + DW;
    localparam int SUM_W = MAXP + 3;
    localparam logic [MAXP:0] HALF = (MAXP + 1)'(1) << (F - 1);
    localparam logic signed [SUM_W-1:0] RMAX = signed'({{(SUM_W - RW + 1){1'b0}}, {(RW - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] RMIN = ~RMAX;
    localparam logic signed [SUM_W-1:0] DMAX = signed'({{(SUM_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;
    localparam logic signed [SUM_W-1:0] PMAX = signed'({{(SUM_W - PW + 1){1'b0}}, {(PW - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;

    // Product rounded by 2^F to nearest, ties away from zero.
    function automatic logic signed [MAXP-1:0] rnd(input logic signed [MAXP-1:0] prod);
        logic signed [MAXP:0] wide;
        logic [MAXP:0]        mag;
        logic signed [MAXP:0] res;
        begin
            wide = (MAXP + 1)'(prod);
            mag  = wide[MAXP] ? unsigned'(-wide) : unsigned'(wide);
            mag  = (mag + HALF) >> F;
            res  = signed'(mag);
            if (wide[MAXP])
                res = -res;
            return res[MAXP-1:0];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] clip(input logic signed [SUM_W-1:0] v,
                                                    input logic signed [SUM_W-1:0] hi,
                                                    input logic signed [SUM_W-1:0] lo);
        begin
            if (v > hi)
                return hi;
            else if (v < lo)
                return lo;
            else
                return v;
        end
    endfunction

    logic signed [RW-1:0] a_in [QUAT_COMPS];
    logic signed [RW-1:0] c_in [QUAT_COMPS];
    logic signed [DW-1:0] d_in [VEC_COMPS];

    always_comb
    begin
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            a_in[k] = signed'(inv[k*RW +: RW]);
            c_in[k] = signed'(child_rot[k*RW +: RW]);
        end
        for (int k = 0; k < VEC_COMPS; k++)
        begin
            d_in[k] = signed'(delta[k*DW +: DW]);
        end
    end

    // Stage 1: raw products.
    logic signed [MAXP-1:0] pr1_next [QUAT_COMPS][QUAT_COMPS];
    logic signed [MAXP-1:0] pr1_reg  [QUAT_COMPS][QUAT_COMPS];
    logic signed [MAXP-1:0] xa1_next [VEC_COMPS];
    logic signed [MAXP-1:0] xb1_next [VEC_COMPS];
    logic signed [MAXP-1:0] xa1_reg  [VEC_COMPS];
    logic signed [MAXP-1:0] xb1_reg  [VEC_COMPS];
    logic signed [RW-1:0]   a1_reg   [QUAT_COMPS];
    logic signed [DW-1:0]   d1_reg   [VEC_COMPS];
    logic                   deg1_reg;
    logic                   vld1_reg;

    always_comb
    begin
        for (int i = 0; i < QUAT_COMPS; i++)
        begin
            for (int j = 0; j < QUAT_COMPS; j++)
            begin
                pr1_next[i][j] = a_in[i] * c_in[j];
            end
        end
    end

    // Cross product u x v: component k is u[k+1]*v[k+2] - u[k+2]*v[k+1], mod 3.
    for (genvar k = 0; k < VEC_COMPS; k++)
    begin : g_cross1
        localparam int I1 = (k + 1) % VEC_COMPS;
        localparam int I2 = (k + 2) % VEC_COMPS;
        assign xa1_next[k] = a_in[I1] * d_in[I2];
        assign xb1_next[k] = a_in[I2] * d_in[I1];
    end

    // Stage 2: rounded products.
    logic signed [MAXP-1:0] rr2_reg [QUAT_COMPS][QUAT_COMPS];
    logic signed [MAXP-1:0] xa2_reg [VEC_COMPS];
    logic signed [MAXP-1:0] xb2_reg [VEC_COMPS];
    logic signed [RW-1:0]   a2_reg  [QUAT_COMPS];
    logic signed [DW-1:0]   d2_reg  [VEC_COMPS];
    logic                   deg2_reg;
    logic                   vld2_reg;

    // Stage 3: quaternion product sums and first cross product.
    logic signed [SUM_W-1:0] rsum3 [QUAT_COMPS];
    logic signed [SUM_W-1:0] csum3 [VEC_COMPS];
    logic signed [SUM_W-1:0] rot3_next [QUAT_COMPS];
    logic signed [SUM_W-1:0] c13_next  [VEC_COMPS];
    logic signed [RW-1:0]    rot3_reg  [QUAT_COMPS];
    logic signed [DW-1:0]    c13_reg   [VEC_COMPS];
    logic signed [RW-1:0]    a3_reg    [QUAT_COMPS];
    logic signed [DW-1:0]    d3_reg    [VEC_COMPS];
    logic                    deg3_reg;
    logic                    vld3_reg;

    always_comb
    begin
        rsum3[0] = rr2_reg[3][0] + rr2_reg[0][3] + rr2_reg[1][2] - rr2_reg[2][1];
        rsum3[1] = rr2_reg[3][1] - rr2_reg[0][2] + rr2_reg[1][3] + rr2_reg[2][0];
        rsum3[2] = rr2_reg[3][2] + rr2_reg[0][1] - rr2_reg[1][0] + rr2_reg[2][3];
        rsum3[3] = rr2_reg[3][3] - rr2_reg[0][0] - rr2_reg[1][1] - rr2_reg[2][2];
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            rot3_next[k] = clip(rsum3[k], RMAX, RMIN);
        end
        for (int k = 0; k < VEC_COMPS; k++)
        begin
            csum3[k]    = xa2_reg[k] - xb2_reg[k];
            c13_next[k] = clip(csum3[k], DMAX, DMIN);
        end
    end

    // Stage 4: second cross product and w * c1.
    logic signed [MAXP-1:0] ya4_next [VEC_COMPS];
    logic signed [MAXP-1:0] yb4_next [VEC_COMPS];
    logic signed [MAXP-1:0] wc4_next [VEC_COMPS];
    logic signed [MAXP-1:0] ya4_reg  [VEC_COMPS];
    logic signed [MAXP-1:0] yb4_reg  [VEC_COMPS];
    logic signed [MAXP-1:0] wc4_reg  [VEC_COMPS];
    logic signed [RW-1:0]   rot4_reg [QUAT_COMPS];
    logic signed [DW-1:0]   d4_reg   [VEC_COMPS];
    logic                   deg4_reg;
    logic                   vld4_reg;

    for (genvar k = 0; k < VEC_COMPS; k++)
    begin : g_cross2
        localparam int I1 = (k + 1) % VEC_COMPS;
        localparam int I2 = (k + 2) % VEC_COMPS;
        assign ya4_next[k] = a3_reg[I1] * c13_reg[I2];
        assign yb4_next[k] = a3_reg[I2] * c13_reg[I1];
        assign wc4_next[k] = a3_reg[QUAT_COMPS-1] * c13_reg[k];
    end

    // Stage 5: rounded products.
    logic signed [MAXP-1:0] ya5_reg  [VEC_COMPS];
    logic signed [MAXP-1:0] yb5_reg  [VEC_COMPS];
    logic signed [MAXP-1:0] wc5_reg  [VEC_COMPS];
    logic signed [RW-1:0]   rot5_reg [QUAT_COMPS];
    logic signed [DW-1:0]   d5_reg   [VEC_COMPS];
    logic                   deg5_reg;
    logic                   vld5_reg;

    // Stage 6: c2 = u x c1, saturated.
    logic signed [SUM_W-1:0] csum6    [VEC_COMPS];
    logic signed [SUM_W-1:0] c26_next [VEC_COMPS];
    logic signed [DW-1:0]    c26_reg  [VEC_COMPS];
    logic signed [MAXP-1:0]  wc6_reg  [VEC_COMPS];
    logic signed [RW-1:0]    rot6_reg [QUAT_COMPS];
    logic signed [DW-1:0]    d6_reg   [VEC_COMPS];
    logic                    deg6_reg;
    logic                    vld6_reg;

    always_comb
    begin
        for (int k = 0; k < VEC_COMPS; k++)
        begin
            csum6[k]    = ya5_reg[k] - yb5_reg[k];
            c26_next[k] = clip(csum6[k], DMAX, DMIN);
        end
    end

    // Stage 7: d + 2 * (w * c1 + c2), saturated; degenerate items read as zero.
    logic signed [SUM_W-1:0]           t7     [VEC_COMPS];
    logic signed [SUM_W-1:0]           res7   [VEC_COMPS];
    logic signed [SUM_W-1:0]           pos7   [VEC_COMPS];
    logic [QUAT_COMPS*RW-1:0]          rot7_next;
    logic [VEC_COMPS*PW-1:0]           pos7_next;
    logic [QUAT_COMPS*RW-1:0]          rot7_reg;
    logic [VEC_COMPS*PW-1:0]           pos7_reg;
    logic                              deg7_reg;
    logic                              vld7_reg;

    always_comb
    begin
        for (int k = 0; k < VEC_COMPS; k++)
        begin
            t7[k]   = wc6_reg[k] + c26_reg[k];
            res7[k] = d6_reg[k] + t7[k] + t7[k];
            pos7[k] = clip(res7[k], PMAX, PMIN);
            pos7_next[k*PW +: PW] = deg6_reg ? '0 : pos7[k][PW-1:0];
        end
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            rot7_next[k*RW +: RW] = deg6_reg ? '0 : rot6_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pr1_reg  <= pr1_next;
            xa1_reg  <= xa1_next;
            xb1_reg  <= xb1_next;
            a1_reg   <= a_in;
            d1_reg   <= d_in;
            deg1_reg <= degenerate;

            for (int i = 0; i < QUAT_COMPS; i++)
            begin
                for (int j = 0; j < QUAT_COMPS; j++)
                begin
                    rr2_reg[i][j] <= rnd(pr1_reg[i][j]);
                end
            end
            for (int k = 0; k < VEC_COMPS; k++)
            begin
                xa2_reg[k] <= rnd(xa1_reg[k]);
                xb2_reg[k] <= rnd(xb1_reg[k]);
            end
            a2_reg   <= a1_reg;
            d2_reg   <= d1_reg;
            deg2_reg <= deg1_reg;

            for (int k = 0; k < QUAT_COMPS; k++)
            begin
                rot3_reg[k] <= rot3_next[k][RW-1:0];
            end
            for (int k = 0; k < VEC_COMPS; k++)
            begin
                c13_reg[k] <= c13_next[k][DW-1:0];
            end
            a3_reg   <= a2_reg;
            d3_reg   <= d2_reg;
            deg3_reg <= deg2_reg;

            ya4_reg  <= ya4_next;
            yb4_reg  <= yb4_next;
            wc4_reg  <= wc4_next;
            rot4_reg <= rot3_reg;
            d4_reg   <= d3_reg;
            deg4_reg <= deg3_reg;

            for (int k = 0; k < VEC_COMPS; k++)
            begin
                ya5_reg[k] <= rnd(ya4_reg[k]);
                yb5_reg[k] <= rnd(yb4_reg[k]);
                wc5_reg[k] <= rnd(wc4_reg[k]);
            end
            rot5_reg <= rot4_reg;
            d5_reg   <= d4_reg;
            deg5_reg <= deg4_reg;

            for (int k = 0; k < VEC_COMPS; k++)
            begin
                c26_reg[k] <= c26_next[k][DW-1:0];
            end
            wc6_reg  <= wc5_reg;
            rot6_reg <= rot5_reg;
            d6_reg   <= d5_reg;
            deg6_reg <= deg5_reg;

            rot7_reg <= rot7_next;
            pos7_reg <= pos7_next;
            deg7_reg <= deg6_reg;
        end
    end

    assign out_valid      = vld7_reg;
    assign local_rot      = rot7_reg;
    assign local_pos      = pos7_reg;
    assign out_degenerate = deg7_reg;

endmodule

// File: hw/rtl/blt_outbuf.sv
// Two-entry output queue that decouples the pipeline from the downstream ready.
module blt_outbuf
    import blt_pkg::*;
#(
    parameter int WIDTH = ROT_WIDTH_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign has_room  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/bone_local_transform.sv
// Top level of the bone local transform: child pose relative to its parent pose.
//
//   channel  | direction | tdata (low bit up)                          | tuser
//   s_axis   | in        | parent_quat, child_quat,                    | -
//            |           | parent_pos_x/y/z, world_pos_x/y/z, zero pad |
//   m_axis   | out       | local_rot_x/y/z/w, local_pos_x/y/z, pad     | degenerate
//
// While the output queue has room, one transaction enters per clock cycle, and
// one leaves per cycle while the receiver is ready. The pipeline depth is set
// by the long division of the parent inverse, which produces one quotient bit
// per pipeline stage. Reset clears only the valid bits and the output queue
// pointers and count. The pipeline advances as a whole while the two-entry
// output queue has room, so input is still taken while one finished result
// waits downstream; a stall neither drops nor repeats anything.
module bone_local_transform
    import blt_pkg::*;
#(
    parameter int  ROT_WIDTH = ROT_WIDTH_DEF,
    parameter int  POS_WIDTH = POS_WIDTH_DEF,
    localparam int IN_BITS   = ((2 * QUAT_BITS + 6 * POS_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS  = ((4 * ROT_WIDTH + 3 * POS_WIDTH + 7) / 8) * 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // parent_quat, child_quat, parent_pos_x, parent_pos_y, parent_pos_z,
    // world_pos_x, world_pos_y, world_pos_z, zero pad
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // local_rot_x, local_rot_y, local_rot_z, local_rot_w,
    // local_pos_x, local_pos_y, local_pos_z, zero pad
    output logic [OUT_BITS-1:0] m_axis_tdata,
    // degenerate
    output logic                m_axis_tuser
);

    localparam int RW     = ROT_WIDTH;
    localparam int PW     = POS_WIDTH;
    localparam int DW     = PW + 1;
    localparam int EXT_W  = (QUAT_COMPS * RW > QUAT_BITS) ? QUAT_COMPS * RW : QUAT_BITS;
    localparam int SIDE_W = QUAT_COMPS * RW + VEC_COMPS * DW;

    // The whole pipeline moves together whenever the output queue has room.
    logic ce;
    logic in_accept;

    assign s_axis_tready = ce;
    assign in_accept     = s_axis_tvalid && ce;

    // Input field split. The translation difference is exact in PW + 1 bits.
    // Quaternion components whose packed position lies above the 64-bit word
    // read as zero, which the zero-extended word gives directly.
    logic [QUAT_BITS-1:0]          parent_quat;
    logic [QUAT_BITS-1:0]          child_quat;
    logic [EXT_W-1:0]              child_word;
    logic [QUAT_COMPS*RW-1:0]      child_rot;
    logic signed [PW-1:0]          parent_pos [VEC_COMPS];
    logic signed [PW-1:0]          world_pos  [VEC_COMPS];
    logic signed [DW-1:0]          diff       [VEC_COMPS];
    logic [VEC_COMPS*DW-1:0]       delta;

    always_comb
    begin
        parent_quat = s_axis_tdata[QUAT_BITS-1:0];
        child_quat  = s_axis_tdata[2*QUAT_BITS-1:QUAT_BITS];
        child_word  = EXT_W'(child_quat);
        for (int k = 0; k < QUAT_COMPS; k++)
        begin
            child_rot[k*RW +: RW] = child_word[(QUAT_COMPS - 1 - k) * RW +: RW];
        end
        for (int k = 0; k < VEC_COMPS; k++)
        begin
            parent_pos[k] = signed'(s_axis_tdata[2 * QUAT_BITS + k * PW +: PW]);
            world_pos[k]  = signed'(s_axis_tdata[2 * QUAT_BITS + (VEC_COMPS + k) * PW +: PW]);
            diff[k]       = DW'(world_pos[k]) - DW'(parent_pos[k]);
            delta[k*DW +: DW] = diff[k];
        end
    end

    // Parent inverse; the child rotation and the translation difference ride
    // alongside it through the division stages.
    logic                     inv_valid;
    logic [QUAT_COMPS*RW-1:0] inv;
    logic                     inv_degenerate;
    logic [SIDE_W-1:0]        inv_side;

    blt_inverse #(
        .ROT_WIDTH  (RW),
        .SIDE_WIDTH (SIDE_W)
    ) u_inverse (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .in_valid    (in_accept),
        .parent_quat (parent_quat),
        .side_in     ({delta, child_rot}),
        .out_valid   (inv_valid),
        .inv         (inv),
        .degenerate  (inv_degenerate),
        .side_out    (inv_side)
    );

    // Local rotation and local translation.
    logic                     res_valid;
    logic [QUAT_COMPS*RW-1:0] local_rot;
    logic [VEC_COMPS*PW-1:0]  local_pos;
    logic                     res_degenerate;

    blt_rotate #(
        .ROT_WIDTH (RW),
        .POS_WIDTH (PW)
    ) u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .ce             (ce),
        .in_valid       (inv_valid),
        .inv            (inv),
        .degenerate     (inv_degenerate),
        .child_rot      (inv_side[QUAT_COMPS*RW-1:0]),
        .delta          (inv_side[SIDE_W-1:QUAT_COMPS*RW]),
        .out_valid      (res_valid),
        .local_rot      (local_rot),
        .local_pos      (local_pos),
        .out_degenerate (res_degenerate)
    );

    // Output queue: the degenerate flag sits above the padded data word.
    logic [OUT_BITS:0] queue_in;
    logic [OUT_BITS:0] queue_out;

    assign queue_in = {res_degenerate, OUT_BITS'({local_pos, local_rot})};

    blt_outbuf #(
        .WIDTH (OUT_BITS + 1)
    ) u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid && ce),
        .push_data (queue_in),
        .has_room  (ce),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (queue_out)
    );

    assign m_axis_tdata = queue_out[OUT_BITS-1:0];
    assign m_axis_tuser = queue_out[OUT_BITS];

endmodule

// File: sim/blt_checker.sv
// Scoreboard for the bone local transform: predicts each local pose and checks the output stream.
module blt_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [271:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           errors,
    output int           pending,
    output int           poses_seen,
    output int           degenerate_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RW   = 16;
    localparam int PW   = 24;
    localparam int FRAC = RW - 2;

    typedef struct {
        logic signed [RW-1:0] rot [4];
        logic signed [PW-1:0] pos [3];
        logic                 degenerate;
    } local_pose_t;

    local_pose_t expected_poses [$];

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Product rounded back by 2^FRAC, ties away from zero.
    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        longint unsigned p;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        p = magnitude(a) * magnitude(b);
        m = (p + (64'd1 << (FRAC - 1))) >> FRAC;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // One component of the parent inverse by restoring division with a round bit.
    function automatic longint inverse_comp(longint num, bit negate, longint unsigned den);
        longint unsigned cap;
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        bit neg;
        bit over;
        cap = 64'd1 << RW;
        neg = (num < 0) != negate;
        a = magnitude(num);
        q = a / den;
        r = a % den;
        over = q > cap;
        for (int i = 0; i < 2 * FRAC + 1 && !over; i++)
        begin
            q = q << 1;
            if (r >= den - r)
            begin
                r = r - (den - r);
                q = q | 64'd1;
            end
            else
                r = r + r;
            if (q > cap)
                over = 1;
        end
        if (over)
            return neg ? -(longint'(1) <<< (RW - 1)) : (longint'(1) <<< (RW - 1)) - 1;
        q = (q + 1) >> 1;
        return clamp(neg ? -longint'(q) : longint'(q), RW);
    endfunction

    function automatic void cross_clamped(input longint u [4], input longint v [3],
                                          output longint o [3]);
        o[0] = clamp(fx_mul(u[1], v[2]) - fx_mul(u[2], v[1]), PW + 1);
        o[1] = clamp(fx_mul(u[2], v[0]) - fx_mul(u[0], v[2]), PW + 1);
        o[2] = clamp(fx_mul(u[0], v[1]) - fx_mul(u[1], v[0]), PW + 1);
    endfunction

    function automatic local_pose_t relative_pose(logic [271:0] d);
        local_pose_t lp;
        longint p [4];
        longint c [4];
        longint a [4];
        longint r [4];
        longint dv [3];
        longint c1 [3];
        longint c2 [3];
        longint unsigned len2;
        longint t;
        len2 = 0;
        for (int k = 0; k < 4; k++)
        begin
            p[k] = longint'($signed(d[(3 - k) * RW +: RW]));
            c[k] = longint'($signed(d[64 + (3 - k) * RW +: RW]));
            len2 += magnitude(p[k]) * magnitude(p[k]);
        end
        for (int k = 0; k < 4; k++)
            lp.rot[k] = '0;
        for (int k = 0; k < 3; k++)
            lp.pos[k] = '0;
        lp.degenerate = (len2 == 0);
        if (len2 == 0)
            return lp;
        for (int k = 0; k < 4; k++)
            a[k] = inverse_comp(p[k], k < 3, len2);
        r[0] = fx_mul(a[3], c[0]) + fx_mul(a[0], c[3]) + fx_mul(a[1], c[2]) - fx_mul(a[2], c[1]);
        r[1] = fx_mul(a[3], c[1]) - fx_mul(a[0], c[2]) + fx_mul(a[1], c[3]) + fx_mul(a[2], c[0]);
        r[2] = fx_mul(a[3], c[2]) + fx_mul(a[0], c[1]) - fx_mul(a[1], c[0]) + fx_mul(a[2], c[3]);
        r[3] = fx_mul(a[3], c[3]) - fx_mul(a[0], c[0]) - fx_mul(a[1], c[1]) - fx_mul(a[2], c[2]);
        for (int k = 0; k < 4; k++)
            lp.rot[k] = RW'(clamp(r[k], RW));
        for (int k = 0; k < 3; k++)
            dv[k] = longint'($signed(d[128 + (3 + k) * PW +: PW]))
                  - longint'($signed(d[128 + k * PW +: PW]));
        cross_clamped(a, dv, c1);
        cross_clamped(a, c1, c2);
        for (int k = 0; k < 3; k++)
        begin
            t = fx_mul(a[3], c1[k]) + c2[k];
            lp.pos[k] = PW'(clamp(dv[k] + 2 * t, PW));
        end
        return lp;
    endfunction

    // Counters start at zero as two-state variables and are only written here.
    always @(posedge clk)
    begin
        local_pose_t want;
        logic signed [RW-1:0] got_rot;
        logic signed [PW-1:0] got_pos;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_poses.push_back(relative_pose(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            poses_seen++;
            if (expected_poses.size() == 0)
            begin
                $error("output transaction with no input pending");
                errors++;
            end
            else
            begin
                want = expected_poses.pop_front();
                if (want.degenerate)
                    degenerate_seen++;
                for (int k = 0; k < 4; k++)
                begin
                    got_rot = m_axis_tdata[k * RW +: RW];
                    if (got_rot !== want.rot[k])
                    begin
                        $error("local_rot[%0d]: expected %0d, got %0d", k, want.rot[k], got_rot);
                        errors++;
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    got_pos = m_axis_tdata[4 * RW + k * PW +: PW];
                    if (got_pos !== want.pos[k])
                    begin
                        $error("local_pos[%0d]: expected %0d, got %0d", k, want.pos[k], got_pos);
                        errors++;
                    end
                end
                if (m_axis_tuser !== want.degenerate)
                begin
                    $error("degenerate: expected %0b, got %0b", want.degenerate, m_axis_tuser);
                    errors++;
                end
            end
        end
        pending = expected_poses.size();
    end

endmodule

// File: sim/bone_local_transform_test.sv
// Testbench top for the bone local transform: stimulus, flow control and verdict.
module bone_local_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_POSES = 750;
    localparam int IDLE_LIMIT   = 4000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [271:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tuser;

    int  errors;
    int  pending;
    int  poses_seen;
    int  degenerate_seen;
    int  idle_cycles = 0;
    bit  backlog_done = 0;

    always #1 clk = ~clk;

    bone_local_transform dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    blt_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .errors(errors),
        .pending(pending),
        .poses_seen(poses_seen),
        .degenerate_seen(degenerate_seen)
    );

    // Offers one pose pair and holds it until the block takes the transaction.
    // The valid is left high so a burst runs back to back.
    task automatic offer_pose(logic [63:0] parent_q, logic [63:0] child_q,
                              logic [71:0] parent_pos, logic [71:0] child_pos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {child_pos, parent_pos, child_q, parent_q};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'(int'($urandom_range(0, 32767)) - 16384);
            1: return 16'($urandom_range(0, 7)) ^ {16{$urandom_range(0, 1) == 1}};
            2: return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Quaternions mostly near unit length so the inverse stays in range; the rest
    // are raw, tiny or zero to drive saturation and the degenerate case.
    function automatic logic [63:0] rand_quat();
        logic [15:0] w;
        case ($urandom_range(0, 9))
            0: return 64'($urandom()) | (64'($urandom()) << 32);
            1: return 64'($urandom_range(0, 3)) << (16 * $urandom_range(0, 3));
            2: return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            default:
            begin
                w = 16'(int'($urandom_range(8000, 16384)));
                if ($urandom_range(0, 1) == 1)
                    w = -w;
                return {16'(int'($urandom_range(0, 18000)) - 9000),
                        16'(int'($urandom_range(0, 18000)) - 9000),
                        16'(int'($urandom_range(0, 18000)) - 9000), w};
            end
        endcase
    endfunction

    function automatic logic [71:0] rand_vec();
        logic [71:0] v;
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 4))
                0: v[k * 24 +: 24] = ($urandom_range(0, 1) == 1) ? 24'h7fffff : 24'h800000;
                1: v[k * 24 +: 24] = 24'($urandom());
                default: v[k * 24 +: 24] = 24'(int'($urandom_range(0, 200000)) - 100000);
            endcase
        return v;
    endfunction

    // Receiver: mostly random stalls in windows of varying density, with one long
    // hold-off partway through so the pipeline and its output queue back up.
    initial
    begin
        int density;
        density = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!backlog_done && poses_seen >= 200)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                backlog_done = 1;
            end
            if ($urandom_range(0, 63) == 0)
                density = $urandom_range(0, 3);
            m_axis_tready <= (density == 0) ? 1'b1 : ($urandom_range(0, density) == 0);
        end
    end

    // Watchdog: counts cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [71:0] zero_vec;
        logic [71:0] max_vec;
        logic [71:0] min_vec;
        zero_vec = '0;
        max_vec = {3{24'h7fffff}};
        min_vec = {3{24'h800000}};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, zero parent, tiny parent, component extremes and
        // translation extremes in both directions.
        offer_pose(64'h0000_0000_0000_4000, 64'h0000_0000_0000_4000, zero_vec, zero_vec);
        offer_pose(64'h0, 64'h1234_5678_9abc_def0, max_vec, min_vec);
        offer_pose(64'h0000_0000_0000_0001, 64'h0000_0000_0000_4000, zero_vec, max_vec);
        offer_pose(64'h0001_0000_0000_0000, 64'hffff_ffff_ffff_ffff, min_vec, max_vec);
        offer_pose(64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, max_vec, min_vec);
        offer_pose(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, min_vec, max_vec);
        offer_pose(64'hffff_ffff_ffff_ffff, 64'h0, max_vec, zero_vec);
        offer_pose(64'h4000_0000_0000_0000, 64'h0000_4000_0000_0000, zero_vec, max_vec);
        offer_pose(64'h0000_4000_0000_0000, 64'h0000_0000_4000_0000, max_vec, min_vec);
        offer_pose(64'h0000_0000_4000_0000, 64'hc000_0000_0000_0000, min_vec, zero_vec);
        offer_pose(64'h2d41_0000_0000_2d41, 64'h0000_2d41_0000_2d41,
                   {24'h000100, 24'h000200, 24'h000300}, {24'h7fff00, 24'h800100, 24'h0});
        offer_pose(64'h0000_0000_0000_c000, 64'h5555_aaaa_5555_aaaa, max_vec, max_vec);
        offer_pose(64'h0000_0000_0000_8000, 64'h7fff_8000_7fff_8000, min_vec, min_vec);
        pause_sender(3);

        for (int n = 0; n < RANDOM_POSES; )
        begin
            int burst;
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int b = 0; b < burst && n < RANDOM_POSES; b++, n++)
                offer_pose(rand_quat(), rand_quat(), rand_vec(), rand_vec());
            pause_sender($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Checked %0d local poses (%0d degenerate parents), with random gaps, stalls",
                 poses_seen, degenerate_seen);
        $display("and one long output hold-off that backed the pipeline up to its input.");
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
